// File: rtl/core/end_sector_sorted_request_queue_assert.svh
// Assertion macros used by the request queue top level.
// Depends on nothing; included by modules that carry assertions.
`ifndef END_SECTOR_SORTED_REQUEST_QUEUE_ASSERT_SVH
`define END_SECTOR_SORTED_REQUEST_QUEUE_ASSERT_SVH

`ifndef SYNTHESIS
`define ESSRQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ESSRQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ESSRQ_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ESSRQ_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: rtl/core/esq_pkg.sv
// Types and constants of the end-sector sorted request queue.
// Depends on nothing; used by the interfaces, the cell and the top level.
`timescale 1ns / 1ps

package esq_pkg;

  localparam int unsigned QueueDepth = 16;
  localparam int unsigned TagBits    = 8;
  localparam int unsigned SectorBits = 48;
  localparam int unsigned LenBits    = 16;
  localparam int unsigned EndBits    = SectorBits + 1;
  localparam int unsigned CntBits    = $clog2(QueueDepth + 1);

  typedef enum logic [2:0] {
    ACT_ADD      = 3'd0,
    ACT_DISPATCH = 3'd1,
    ACT_MERGE    = 3'd2,
    ACT_FORMER   = 3'd3,
    ACT_LATTER   = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NONE     = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef struct packed {
    logic [TagBits-1:0]    tag;
    logic [SectorBits-1:0] start_sector;
    logic [EndBits-1:0]    end_sector;
    logic                  is_write;
  } entry_t;

  typedef struct packed {
    action_e            op;
    logic               full;
    logic [TagBits-1:0] tag;
    entry_t             entry;
  } cmd_t;

  typedef struct packed {
    logic take;
    logic seen;
    logic first;
  } link_t;

endpackage

// File: rtl/core/esq_req_if.sv
// Request channel of the sorted request queue.
// Depends on esq_pkg for field widths.
`timescale 1ns / 1ps

interface esq_req_if;
  logic                            valid;
  logic                            ready;
  logic [2:0]                      action;
  logic [esq_pkg::TagBits-1:0]     request_tag;
  logic [esq_pkg::SectorBits-1:0]  start_sector;
  logic [esq_pkg::LenBits-1:0]     sector_count;
  logic                            is_write;

  modport source (output valid, action, request_tag, start_sector, sector_count, is_write,
                  input ready);
  modport sink (input valid, action, request_tag, start_sector, sector_count, is_write,
                output ready);
endinterface

// File: rtl/core/esq_rsp_if.sv
// Response channel of the sorted request queue.
// Depends on esq_pkg for field widths.
`timescale 1ns / 1ps

interface esq_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      status;
  logic [esq_pkg::TagBits-1:0]     out_tag;
  logic [esq_pkg::SectorBits-1:0]  out_start_sector;
  logic                            out_is_write;
  logic                            queue_empty;
  logic [esq_pkg::CntBits-1:0]     queued_count;

  modport source (output valid, status, out_tag, out_start_sector, out_is_write, queue_empty,
                  queued_count, input ready);
  modport sink (input valid, status, out_tag, out_start_sector, out_is_write, queue_empty,
                queued_count, output ready);
endinterface

// File: rtl/core/esq_cell.sv
// One slot of the sorted queue: holds an entry and trades it with its neighbours.
// Depends on esq_pkg.
`timescale 1ns / 1ps

module esq_cell (
  input  logic            clk_i,
  input  logic            en_i,
  input  esq_pkg::cmd_t   cmd_i,
  input  logic            valid_i,
  input  esq_pkg::entry_t prev_entry_i,
  input  esq_pkg::link_t  prev_link_i,
  input  esq_pkg::entry_t next_entry_i,
  input  logic            next_first_i,
  output esq_pkg::entry_t entry_o,
  output esq_pkg::link_t  link_o,
  output logic            sel_o
);

  esq_pkg::entry_t entry_q, entry_d;
  logic            match;

  assign match          = valid_i && (entry_q.tag == cmd_i.tag);
  assign link_o.take    = !valid_i || (entry_q.end_sector >= cmd_i.entry.end_sector);
  assign link_o.seen    = prev_link_i.seen || match;
  assign link_o.first   = match && !prev_link_i.seen;
  assign entry_o        = entry_q;

  assign sel_o = valid_i && (((cmd_i.op == esq_pkg::ACT_FORMER) && next_first_i) ||
                             ((cmd_i.op == esq_pkg::ACT_LATTER) && prev_link_i.first));

  always_comb begin
    entry_d = entry_q;
    case (cmd_i.op)
      esq_pkg::ACT_ADD: begin
        if (!cmd_i.full && link_o.take) begin
          entry_d = prev_link_i.take ? prev_entry_i : cmd_i.entry;
        end
      end
      esq_pkg::ACT_DISPATCH: begin
        entry_d = next_entry_i;
      end
      esq_pkg::ACT_MERGE: begin
        if (link_o.seen) begin
          entry_d = next_entry_i;
        end
      end
      default: begin
        entry_d = entry_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      entry_q <= entry_d;
    end
  end

endmodule

// File: rtl/core/end_sector_sorted_request_queue.sv
// Top level of the end-sector sorted request queue: a row of esq_cell slots.
// Depends on esq_pkg, esq_req_if, esq_rsp_if, esq_cell and the assertion header.
// A response is registered: it appears in the cycle after its request is accepted.
// Throughput: one request per cycle while no response is stalled; every slot compares and shifts in the same cycle.
// Reset clears the fill count and the response valid; slot contents stay undefined.
`timescale 1ns / 1ps
`include "end_sector_sorted_request_queue_assert.svh"

module end_sector_sorted_request_queue (
  input  logic      clk_i,
  input  logic      rst_ni,
  esq_req_if.sink   req_i,
  esq_rsp_if.source rsp_o
);

  localparam int unsigned Depth = esq_pkg::QueueDepth;
  localparam int unsigned CntW  = esq_pkg::CntBits;

  esq_pkg::cmd_t   cmd;
  esq_pkg::entry_t entries [Depth];
  esq_pkg::link_t  links   [Depth];
  logic [Depth-1:0] sel;
  logic [Depth-1:0] valid;
  logic             accept;
  logic             found;
  logic             empty;
  logic [CntW-1:0]  count_q, count_d;
  esq_pkg::entry_t  pick;
  logic             add_ok;
  logic             pop_ok;
  logic             stalled;

  logic                           rsp_valid_q;
  esq_pkg::status_e               status_q, status_d;
  logic [esq_pkg::TagBits-1:0]    tag_q, tag_d;
  logic [esq_pkg::SectorBits-1:0] start_q, start_d;
  logic                           write_q, write_d;

  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;

  assign empty             = (count_q == '0);
  assign cmd.op            = esq_pkg::action_e'(req_i.action);
  assign cmd.full          = (count_q == CntW'(Depth));
  assign cmd.tag           = req_i.request_tag;
  assign cmd.entry.tag          = req_i.request_tag;
  assign cmd.entry.start_sector = req_i.start_sector;
  assign cmd.entry.is_write     = req_i.is_write;
  assign cmd.entry.end_sector   = {1'b0, req_i.start_sector} +
      {{(esq_pkg::EndBits - esq_pkg::LenBits){1'b0}}, req_i.sector_count};

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    esq_pkg::entry_t prev_entry, next_entry;
    esq_pkg::link_t  prev_link;
    logic            next_first;

    assign valid[i] = (CntW'(i) < count_q);

    if (i == 0) begin : g_head
      assign prev_entry = '0;
      assign prev_link  = '0;
    end else begin : g_mid
      assign prev_entry = entries[i-1];
      assign prev_link  = links[i-1];
    end

    if (i == Depth - 1) begin : g_tail
      assign next_entry = '0;
      assign next_first = 1'b0;
    end else begin : g_body
      assign next_entry = entries[i+1];
      assign next_first = links[i+1].first;
    end

    esq_cell u_cell (
      .clk_i        (clk_i),
      .en_i         (accept),
      .cmd_i        (cmd),
      .valid_i      (valid[i]),
      .prev_entry_i (prev_entry),
      .prev_link_i  (prev_link),
      .next_entry_i (next_entry),
      .next_first_i (next_first),
      .entry_o      (entries[i]),
      .link_o       (links[i]),
      .sel_o        (sel[i])
    );
  end

  assign found = links[Depth-1].seen;

  always_comb begin
    pick = '0;
    for (int i = 0; i < Depth; i++) begin
      pick = pick | (sel[i] ? entries[i] : '0);
    end
  end

  always_comb begin
    count_d  = count_q;
    status_d = esq_pkg::ST_OK;
    tag_d    = '0;
    start_d  = '0;
    write_d  = 1'b0;
    case (cmd.op)
      esq_pkg::ACT_ADD: begin
        if (cmd.full) begin
          status_d = esq_pkg::ST_FULL;
        end else begin
          count_d = count_q + 1'b1;
        end
      end
      esq_pkg::ACT_DISPATCH: begin
        if (empty) begin
          status_d = esq_pkg::ST_NONE;
        end else begin
          count_d = count_q - 1'b1;
          tag_d   = entries[0].tag;
          start_d = entries[0].start_sector;
          write_d = entries[0].is_write;
        end
      end
      esq_pkg::ACT_MERGE: begin
        if (found) begin
          count_d = count_q - 1'b1;
        end else begin
          status_d = esq_pkg::ST_NOTFOUND;
        end
      end
      esq_pkg::ACT_FORMER, esq_pkg::ACT_LATTER: begin
        if (!found) begin
          status_d = esq_pkg::ST_NOTFOUND;
        end else if (sel == '0) begin
          status_d = esq_pkg::ST_NONE;
        end else begin
          tag_d   = pick.tag;
          start_d = pick.start_sector;
          write_d = pick.is_write;
        end
      end
      default: begin
        status_d = esq_pkg::ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      tag_q    <= tag_d;
      start_q  <= start_d;
      write_q  <= write_d;
    end
  end

  assign rsp_o.valid            = rsp_valid_q;
  assign rsp_o.status           = status_q;
  assign rsp_o.out_tag          = tag_q;
  assign rsp_o.out_start_sector = start_q;
  assign rsp_o.out_is_write     = write_q;
  assign rsp_o.queued_count     = count_q;
  assign rsp_o.queue_empty      = empty;

  assign add_ok  = accept && (cmd.op == esq_pkg::ACT_ADD) && !cmd.full;
  assign pop_ok  = accept && (cmd.op == esq_pkg::ACT_DISPATCH) && !empty;
  assign stalled = rsp_valid_q && !rsp_o.ready;

  `ESSRQ_ASSERT_IMP(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= CntW'(Depth))
  `ESSRQ_ASSERT_NXT(a_add_grows, clk_i, rst_ni, add_ok, count_q == $past(count_q) + 1'b1)
  `ESSRQ_ASSERT_NXT(a_pop_shrinks, clk_i, rst_ni, pop_ok, count_q == $past(count_q) - 1'b1)
  `ESSRQ_ASSERT_IMP(a_one_neighbour, clk_i, rst_ni, 1'b1, $onehot0(sel))
  `ESSRQ_ASSERT_NXT(a_stall_holds, clk_i, rst_ni, stalled, rsp_valid_q && $stable(count_q))

endmodule

// File: test/tb_end_sector_sorted_request_queue.sv
// Self-checking testbench for the end-sector sorted request queue.
// Depends on esq_pkg, esq_req_if, esq_rsp_if and end_sector_sorted_request_queue.
// Requests go in with random gaps; every response is checked against a local queue model.
`timescale 1ns / 1ps

module tb_end_sector_sorted_request_queue;
  import esq_pkg::*;

  localparam logic [2:0]  ACT_SPARE_FIRST = 3'd5;
  localparam logic [2:0]  ACT_SPARE_LAST  = 3'd7;
  localparam int unsigned CYCLE_LIMIT     = 600000;
  localparam int unsigned DRAIN_CYCLES    = 10;
  localparam int unsigned MAX_REPORTS     = 10;

  typedef struct packed {
    status_e               status;
    logic [TagBits-1:0]    tag;
    logic [SectorBits-1:0] start_sector;
    logic                  is_write;
    logic                  queue_empty;
    logic [CntBits-1:0]    queued_count;
  } queue_result_t;

  logic clk_i;
  logic rst_ni;

  esq_req_if req_if ();
  esq_rsp_if rsp_if ();

  end_sector_sorted_request_queue dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  entry_t        held_q[$];
  queue_result_t result_q[$];
  int unsigned   mismatch_count;
  int unsigned   cycle_count;
  bit            steady;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count == CYCLE_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  function automatic queue_result_t apply_request(input logic [2:0] act,
                                                  input logic [TagBits-1:0] tag,
                                                  input logic [SectorBits-1:0] start,
                                                  input logic [LenBits-1:0] len,
                                                  input logic wr);
    queue_result_t    r;
    entry_t           e;
    logic [EndBits-1:0] fin;
    int               pos;
    int               hit;
    r        = '0;
    r.status = ST_OK;
    hit      = -1;
    for (int i = held_q.size() - 1; i >= 0; i--) begin
      if (held_q[i].tag == tag) hit = i;
    end
    case (act)
      ACT_ADD: begin
        if (held_q.size() >= QueueDepth) begin
          r.status = ST_FULL;
        end else begin
          fin = {1'b0, start} + EndBits'(len);
          pos = held_q.size();
          for (int i = held_q.size() - 1; i >= 0; i--) begin
            if (held_q[i].end_sector >= fin) pos = i;
          end
          e.tag          = tag;
          e.start_sector = start;
          e.end_sector   = fin;
          e.is_write     = wr;
          held_q.insert(pos, e);
        end
      end
      ACT_DISPATCH: begin
        if (held_q.size() == 0) begin
          r.status = ST_NONE;
        end else begin
          r.tag          = held_q[0].tag;
          r.start_sector = held_q[0].start_sector;
          r.is_write     = held_q[0].is_write;
          held_q.delete(0);
        end
      end
      ACT_MERGE, ACT_FORMER, ACT_LATTER: begin
        if (hit < 0) begin
          r.status = ST_NOTFOUND;
        end else if (act == ACT_MERGE) begin
          held_q.delete(hit);
        end else begin
          pos = (act == ACT_FORMER) ? hit - 1 : hit + 1;
          if (pos < 0 || pos >= held_q.size()) begin
            r.status = ST_NONE;
          end else begin
            r.tag          = held_q[pos].tag;
            r.start_sector = held_q[pos].start_sector;
            r.is_write     = held_q[pos].is_write;
          end
        end
      end
      default: ;
    endcase
    r.queue_empty  = (held_q.size() == 0);
    r.queued_count = CntBits'(held_q.size());
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Must be called in the time step of a rising edge.
  task automatic send_request(input logic [2:0] act, input logic [TagBits-1:0] tag,
                              input logic [SectorBits-1:0] start,
                              input logic [LenBits-1:0] len, input logic wr);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid        <= 1'b1;
    req_if.action       <= act;
    req_if.request_tag  <= tag;
    req_if.start_sector <= start;
    req_if.sector_count <= len;
    req_if.is_write     <= wr;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    result_q.push_back(apply_request(act, tag, start, len, wr));
  endtask

  task automatic wait_for_responses();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (result_q.size() != 0);
  endtask

  task automatic send_random_request(input int add_pct, input int dispatch_pct);
    logic [2:0]            act;
    logic [TagBits-1:0]    tag;
    logic [SectorBits-1:0] start;
    logic [LenBits-1:0]    len;
    logic [63:0]           wide;
    int                    r;
    r = $urandom_range(0, 99);
    if (r < add_pct) act = ACT_ADD;
    else if (r < add_pct + dispatch_pct) act = ACT_DISPATCH;
    else if (r >= 97) act = 3'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST));
    else begin
      case ($urandom_range(0, 2))
        0: act = ACT_MERGE;
        1: act = ACT_FORMER;
        default: act = ACT_LATTER;
      endcase
    end
    if (act != ACT_ADD && held_q.size() != 0 && $urandom_range(0, 99) < 80)
      tag = held_q[$urandom_range(0, held_q.size() - 1)].tag;
    else if ($urandom_range(0, 99) < 30)
      tag = TagBits'($urandom_range(0, 7));
    else
      tag = TagBits'($urandom_range(0, 255));
    wide = {$urandom, $urandom};
    case ($urandom_range(0, 3))
      0: start = SectorBits'($urandom_range(0, 63));
      1: start = '1 - SectorBits'($urandom_range(0, 63));
      default: start = wide[SectorBits-1:0];
    endcase
    r = $urandom_range(0, 99);
    if (r < 15) len = '0;
    else if (r < 30) len = '1;
    else if (r < 50) len = LenBits'($urandom_range(0, 4));
    else len = LenBits'($urandom);
    send_request(act, tag, start, len, 1'($urandom_range(0, 1)));
  endtask

  task automatic test_empty_queue();
    send_request(ACT_DISPATCH, 8'd0, '0, '0, 1'b0);
    send_request(ACT_MERGE, 8'd5, '0, '0, 1'b0);
    send_request(ACT_FORMER, 8'd5, '0, '0, 1'b0);
    send_request(ACT_LATTER, 8'd5, '0, '0, 1'b0);
  endtask

  task automatic test_extreme_sectors();
    send_request(ACT_ADD, 8'd255, '1, '1, 1'b1);
    send_request(ACT_ADD, 8'd0, '0, '0, 1'b0);
    send_request(ACT_FORMER, 8'd255, '0, '0, 1'b0);
    send_request(ACT_LATTER, 8'd0, '0, '0, 1'b0);
    send_request(ACT_LATTER, 8'd255, '0, '0, 1'b0);
    send_request(ACT_FORMER, 8'd0, '0, '0, 1'b0);
  endtask

  // Requests sharing an end sector leave in reverse order of arrival.
  task automatic test_equal_end_order();
    send_request(ACT_ADD, 8'd1, 48'd100, 16'd20, 1'b1);
    send_request(ACT_ADD, 8'd2, 48'd110, 16'd10, 1'b0);
    send_request(ACT_DISPATCH, 8'd0, '0, '0, 1'b0);
    send_request(ACT_DISPATCH, 8'd0, '0, '0, 1'b0);
    send_request(ACT_DISPATCH, 8'd0, '0, '0, 1'b0);
  endtask

  task automatic test_duplicate_tags();
    send_request(ACT_ADD, 8'd7, 48'd500, 16'd1, 1'b0);
    send_request(ACT_ADD, 8'd7, 48'd400, 16'd1, 1'b1);
    send_request(ACT_MERGE, 8'd7, '0, '0, 1'b0);
    send_request(ACT_LATTER, 8'd7, '0, '0, 1'b0);
  endtask

  task automatic test_spare_actions();
    for (int a = ACT_SPARE_FIRST; a <= ACT_SPARE_LAST; a++)
      send_request(3'(a), 8'hAA, '1, '1, 1'b1);
  endtask

  task automatic test_full_queue();
    while (held_q.size() < QueueDepth) send_random_request(100, 0);
    send_random_request(100, 0);
    repeat (20) send_random_request(30, 0);
  endtask

  task automatic test_random_traffic(input int items, input int add_pct,
                                     input int dispatch_pct);
    repeat (items) send_random_request(add_pct, dispatch_pct);
  endtask

  task automatic test_back_to_back(input int items);
    steady = 1'b1;
    repeat (items) send_random_request(45, 20);
    steady = 1'b0;
  endtask

  initial begin : response_ready
    int   hold;
    int   r;
    hold = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold > 0) begin
        hold--;
      end else if (steady) begin
        rsp_if.ready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 65) begin
          rsp_if.ready <= 1'b1;
          hold = $urandom_range(0, 4);
        end else if (r < 90) begin
          rsp_if.ready <= 1'b0;
          hold = $urandom_range(0, 2);
        end else begin
          rsp_if.ready <= 1'b0;
          hold = $urandom_range(8, 40);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    queue_result_t exp_r;
    if (rst_ni && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      if (result_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("%0t: response with no request outstanding", $realtime);
      end else begin
        exp_r = result_q.pop_front();
        if (rsp_if.status !== exp_r.status || rsp_if.out_tag !== exp_r.tag ||
            rsp_if.out_start_sector !== exp_r.start_sector ||
            rsp_if.out_is_write !== exp_r.is_write ||
            rsp_if.queue_empty !== exp_r.queue_empty ||
            rsp_if.queued_count !== exp_r.queued_count) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t: expected status %0d tag %0d start %h wr %b empty %b count %0d",
                     $realtime, exp_r.status, exp_r.tag, exp_r.start_sector,
                     exp_r.is_write, exp_r.queue_empty, exp_r.queued_count);
            $display("%0t: actual   status %0d tag %0d start %h wr %b empty %b count %0d",
                     $realtime, rsp_if.status, rsp_if.out_tag, rsp_if.out_start_sector,
                     rsp_if.out_is_write, rsp_if.queue_empty, rsp_if.queued_count);
          end
        end
      end
    end
  end

  initial begin
    steady              = 1'b0;
    rst_ni              <= 1'b0;
    req_if.valid        <= 1'b0;
    req_if.action       <= ACT_ADD;
    req_if.request_tag  <= '0;
    req_if.start_sector <= '0;
    req_if.sector_count <= '0;
    req_if.is_write     <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_queue();
    test_extreme_sectors();
    test_equal_end_order();
    test_duplicate_tags();
    test_spare_actions();
    test_random_traffic(300, 45, 20);
    test_full_queue();
    test_random_traffic(150, 75, 5);
    test_back_to_back(150);
    wait_for_responses();
    test_random_traffic(200, 20, 40);
    test_random_traffic(350, 40, 20);

    wait_for_responses();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && result_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
